// ----- hw/rtl/assert_macros.svh -----
// Assertion macros shared by the RTL of the leg kinematics block.
// Define ASSERT_OFF to compile every check away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Same-cycle implication, disabled while reset is low
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication, disabled while reset is low
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ----- hw/rtl/lik_pkg.sv -----
// Shared constants and the CORDIC angle table of the leg kinematics block.
// No dependencies.
`timescale 1ns / 1ps
package lik_pkg;
  // configuration register indexes
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_FEMUR_OFFSET = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FEMUR_HEIGHT = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FEMUR_LENGTH = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TIBIA_LENGTH = 8'd3;

  // datapath widths
  localparam int COORD_W   = 16;  // saturated coordinate
  localparam int WIDE_W    = 56;  // atan2 operands
  localparam int CORDIC_W  = 34;  // normalised CORDIC x/y
  localparam int ANG_W     = 28;  // angle accumulator, 1/65536 degree
  localparam int CORDIC_STAGES = 16;
  localparam int EPS_UNITS = 65;
  localparam int ROUND_SHIFT = 12;
  localparam int RIGHT_ANGLE_FINE = 90 * 65536;
  localparam int HALF_TURN_FINE   = 180 * 65536;

  // atan(2^-i) in 1/65536 degree
  function automatic logic signed [ANG_W-1:0] cordic_angle(input int i);
    logic signed [ANG_W-1:0] a;
    case (i)
      0:  a = 28'sd2949120;
      1:  a = 28'sd1740967;
      2:  a = 28'sd919879;
      3:  a = 28'sd466945;
      4:  a = 28'sd234379;
      5:  a = 28'sd117304;
      6:  a = 28'sd58666;
      7:  a = 28'sd29335;
      8:  a = 28'sd14668;
      9:  a = 28'sd7334;
      10: a = 28'sd3667;
      11: a = 28'sd1833;
      12: a = 28'sd917;
      13: a = 28'sd458;
      14: a = 28'sd229;
      15: a = 28'sd115;
      default: a = '0;
    endcase
    return a;
  endfunction
endpackage

// ----- hw/rtl/lik_sqrt_cell.sv -----
// One digit cell of the pipelined integer square root.
// Depends on nothing; used by lik_sqrt.
`timescale 1ns / 1ps
module lik_sqrt_cell #(
  parameter int W    = 32,
  parameter int STEP = 0,
  parameter int TW   = 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          valid_i,
  input  logic [W-1:0]  n_i,
  input  logic [W-1:0]  r_i,
  input  logic [TW-1:0] tag_i,
  output logic          valid_o,
  output logic [W-1:0]  n_o,
  output logic [W-1:0]  r_o,
  output logic [TW-1:0] tag_o
);
  localparam logic [W-1:0] BIT = W'(1) << (W - 2 - 2 * STEP);

  logic [W:0]   trial;
  logic         take;
  logic [W-1:0] n_nxt, r_nxt;
  logic         valid_r;
  logic [W-1:0] n_r, r_r;
  logic [TW-1:0] tag_r;

  // try to subtract this digit
  always_comb begin
    trial = {1'b0, r_i} + {1'b0, BIT};
    take  = {1'b0, n_i} >= trial;
    n_nxt = take ? n_i - trial[W-1:0] : n_i;
    r_nxt = take ? (r_i >> 1) + BIT : (r_i >> 1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) valid_r <= 1'b0;
    else valid_r <= valid_i;
  end

  always_ff @(posedge clk) begin
    n_r   <= n_nxt;
    r_r   <= r_nxt;
    tag_r <= tag_i;
  end

  assign valid_o = valid_r;
  assign n_o     = n_r;
  assign r_o     = r_r;
  assign tag_o   = tag_r;
endmodule

// ----- hw/rtl/lik_sqrt.sv -----
// Pipelined rounded integer square root: a chain of W/2 digit cells and a rounding stage.
// Depends on lik_sqrt_cell.
`timescale 1ns / 1ps
module lik_sqrt #(
  parameter int W  = 32,
  parameter int TW = 1
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           valid_i,
  input  logic [W-1:0]   rad_i,
  input  logic [TW-1:0]  tag_i,
  output logic           valid_o,
  output logic [W/2-1:0] root_o,
  output logic [TW-1:0]  tag_o
);
  localparam int N = W / 2;

  logic [N:0]         v;
  logic [N:0][W-1:0]  n;
  logic [N:0][W-1:0]  r;
  logic [N:0][TW-1:0] t;

  logic           valid_r;
  logic [W/2-1:0] root_r;
  logic [TW-1:0]  tag_r;

  assign v[0] = valid_i;
  assign n[0] = rad_i;
  assign r[0] = '0;
  assign t[0] = tag_i;

  // one result bit per cell
  for (genvar i = 0; i < N; i++) begin : g_cell
    lik_sqrt_cell #(.W(W), .STEP(i), .TW(TW)) u_cell (
      .clk(clk), .rst_n(rst_n),
      .valid_i(v[i]), .n_i(n[i]), .r_i(r[i]), .tag_i(t[i]),
      .valid_o(v[i+1]), .n_o(n[i+1]), .r_o(r[i+1]), .tag_o(t[i+1])
    );
  end

  // round up when the remainder exceeds the root
  always_ff @(posedge clk) begin
    if (!rst_n) valid_r <= 1'b0;
    else valid_r <= v[N];
  end

  always_ff @(posedge clk) begin
    root_r <= (n[N] > r[N]) ? r[N][W/2-1:0] + 1'b1 : r[N][W/2-1:0];
    tag_r  <= t[N];
  end

  assign valid_o = valid_r;
  assign root_o  = root_r;
  assign tag_o   = tag_r;
endmodule

// ----- hw/rtl/lik_cordic_cell.sv -----
// One vectoring-mode CORDIC rotation cell.
// Depends on lik_pkg for widths and the angle table.
`timescale 1ns / 1ps
module lik_cordic_cell #(
  parameter int STEP = 0,
  parameter int TW   = 1
) (
  input  logic clk,
  input  logic rst_n,
  input  logic valid_i,
  input  logic signed [lik_pkg::CORDIC_W-1:0] x_i,
  input  logic signed [lik_pkg::CORDIC_W-1:0] y_i,
  input  logic signed [lik_pkg::ANG_W-1:0]    z_i,
  input  logic [TW-1:0] tag_i,
  output logic valid_o,
  output logic signed [lik_pkg::CORDIC_W-1:0] x_o,
  output logic signed [lik_pkg::CORDIC_W-1:0] y_o,
  output logic signed [lik_pkg::ANG_W-1:0]    z_o,
  output logic [TW-1:0] tag_o
);
  localparam logic signed [lik_pkg::ANG_W-1:0] ANGLE = lik_pkg::cordic_angle(STEP);

  logic signed [lik_pkg::CORDIC_W-1:0] x_nxt, y_nxt, x_r, y_r;
  logic signed [lik_pkg::ANG_W-1:0]    z_nxt, z_r;
  logic valid_r;
  logic [TW-1:0] tag_r;

  // rotate towards the x axis; hold when y is zero
  always_comb begin
    x_nxt = x_i;
    y_nxt = y_i;
    z_nxt = z_i;
    if (y_i > 0) begin
      x_nxt = x_i + (y_i >>> STEP);
      y_nxt = y_i - (x_i >>> STEP);
      z_nxt = z_i + ANGLE;
    end else if (y_i < 0) begin
      x_nxt = x_i - (y_i >>> STEP);
      y_nxt = y_i + (x_i >>> STEP);
      z_nxt = z_i - ANGLE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) valid_r <= 1'b0;
    else valid_r <= valid_i;
  end

  always_ff @(posedge clk) begin
    x_r   <= x_nxt;
    y_r   <= y_nxt;
    z_r   <= z_nxt;
    tag_r <= tag_i;
  end

  assign valid_o = valid_r;
  assign x_o     = x_r;
  assign y_o     = y_r;
  assign z_o     = z_r;
  assign tag_o   = tag_r;
endmodule

// ----- hw/rtl/lik_atan2.sv -----
// Pipelined atan2: half-plane fold, two normalising stages, then a chain of CORDIC cells.
// Depends on lik_pkg and lik_cordic_cell.
`timescale 1ns / 1ps
module lik_atan2 #(
  parameter int TW = 1
) (
  input  logic clk,
  input  logic rst_n,
  input  logic valid_i,
  input  logic signed [lik_pkg::WIDE_W-1:0] y_i,
  input  logic signed [lik_pkg::WIDE_W-1:0] x_i,
  input  logic [TW-1:0] tag_i,
  output logic valid_o,
  output logic signed [lik_pkg::ANG_W-1:0] angle_o,
  output logic [TW-1:0] tag_o
);
  localparam int W  = lik_pkg::WIDE_W;
  localparam int CW = lik_pkg::CORDIC_W;
  localparam int AW = lik_pkg::ANG_W;
  localparam int NS = lik_pkg::CORDIC_STAGES;

  // fold stage
  logic signed [W-1:0] fx, fy;
  logic [W-1:0]        fax, fay;
  logic signed [AW-1:0] fbase;
  logic a_valid_r, a_zero_r;
  logic signed [W-1:0] a_x_r, a_y_r;
  logic [W-1:0]        a_m_r;
  logic signed [AW-1:0] a_base_r;
  logic [TW-1:0] a_tag_r;

  always_comb begin
    fx    = x_i;
    fy    = y_i;
    fbase = '0;
    if (x_i[W-1]) begin
      fx    = -x_i;
      fy    = -y_i;
      fbase = y_i[W-1] ? -AW'(lik_pkg::HALF_TURN_FINE) : AW'(lik_pkg::HALF_TURN_FINE);
    end
    fax = fx[W-1] ? W'(-fx) : W'(fx);
    fay = fy[W-1] ? W'(-fy) : W'(fy);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) a_valid_r <= 1'b0;
    else a_valid_r <= valid_i;
  end

  always_ff @(posedge clk) begin
    a_x_r    <= fx;
    a_y_r    <= fy;
    a_m_r    <= (fax > fay) ? fax : fay;
    a_base_r <= fbase;
    a_zero_r <= (x_i == '0) && (y_i == '0);
    a_tag_r  <= tag_i;
  end

  // shift down until the larger magnitude is below 2^30
  logic signed [W-1:0] rx, ry;
  logic [W-1:0]        rm;
  logic b_valid_r, b_zero_r;
  logic signed [W-1:0] b_x_r, b_y_r;
  logic [W-1:0]        b_m_r;
  logic signed [AW-1:0] b_base_r;
  logic [TW-1:0] b_tag_r;

  always_comb begin
    rx = a_x_r;
    ry = a_y_r;
    rm = a_m_r;
    for (int i = 0; i < 5; i++) begin
      if (rm >= (W'(1) << (29 + (16 >> i)))) begin
        rx = rx >>> (16 >> i);
        ry = ry >>> (16 >> i);
        rm = rm >> (16 >> i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) b_valid_r <= 1'b0;
    else b_valid_r <= a_valid_r;
  end

  always_ff @(posedge clk) begin
    b_x_r    <= rx;
    b_y_r    <= ry;
    b_m_r    <= rm;
    b_base_r <= a_base_r;
    b_zero_r <= a_zero_r;
    b_tag_r  <= a_tag_r;
  end

  // shift up until the larger magnitude reaches 2^29
  logic signed [W-1:0] lx, ly;
  logic [W-1:0]        lm;
  logic c_valid_r;
  logic signed [CW-1:0] c_x_r, c_y_r;
  logic signed [AW-1:0] c_base_r;
  logic [TW-1:0] c_tag_r;

  always_comb begin
    lx = b_x_r;
    ly = b_y_r;
    lm = b_m_r;
    for (int i = 0; i < 5; i++) begin
      if (lm < (W'(1) << (30 - (16 >> i)))) begin
        lx = lx <<< (16 >> i);
        ly = ly <<< (16 >> i);
        lm = lm << (16 >> i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) c_valid_r <= 1'b0;
    else c_valid_r <= b_valid_r;
  end

  // a zero vector leaves every cell idle and gives zero
  always_ff @(posedge clk) begin
    c_x_r    <= b_zero_r ? '0 : lx[CW-1:0];
    c_y_r    <= b_zero_r ? '0 : ly[CW-1:0];
    c_base_r <= b_zero_r ? '0 : b_base_r;
    c_tag_r  <= b_tag_r;
  end

  // rotation chain
  logic [NS:0]                 v;
  logic [NS:0][CW-1:0]         cx, cy;
  logic [NS:0][AW-1:0]         cz;
  logic [NS:0][TW-1:0]         ct;

  assign v[0]  = c_valid_r;
  assign cx[0] = c_x_r;
  assign cy[0] = c_y_r;
  assign cz[0] = c_base_r;
  assign ct[0] = c_tag_r;

  for (genvar i = 0; i < NS; i++) begin : g_cell
    lik_cordic_cell #(.STEP(i), .TW(TW)) u_cell (
      .clk(clk), .rst_n(rst_n),
      .valid_i(v[i]),
      .x_i($signed(cx[i])), .y_i($signed(cy[i])), .z_i($signed(cz[i])), .tag_i(ct[i]),
      .valid_o(v[i+1]), .x_o(cx[i+1]), .y_o(cy[i+1]), .z_o(cz[i+1]), .tag_o(ct[i+1])
    );
  end

  assign valid_o = v[NS];
  assign angle_o = $signed(cz[NS]);
  assign tag_o   = ct[NS];
endmodule

// ----- hw/rtl/leg_inverse_kinematics.sv -----
// Top level of the three-joint leg inverse kinematics pipeline.
// Depends on lik_pkg, lik_sqrt, lik_atan2 and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"
// Takes one foot target per clock while busy is low and returns its result as
// one strobe on out_valid with yaw, femur and tibia commands in 1/16 degree plus a reachable
// flag. The rate is one target per clock throughout: both square roots (16 and 32 digit cells)
// and the three atan2 units (16 CORDIC cells each) are cell chains that take a new operand
// every cycle. busy is set in reset and clears at the first edge after its release. Results are
// presented for one cycle and cannot be held off, so the receiver must take every strobe.
// Write the configuration registers only while no transaction is in flight.
module leg_inverse_kinematics #(
  parameter int ANGLE_BITS = 14,
  parameter int COORD_BITS = 16
) (
  input  logic clk,
  input  logic rst_n,
  // command side
  input  logic start,
  output logic busy,
  input  logic signed [COORD_BITS-1:0] in_target_x,
  input  logic signed [COORD_BITS-1:0] in_target_y,
  input  logic signed [COORD_BITS-1:0] in_target_z,
  // result side
  output logic out_valid,
  output logic signed [ANGLE_BITS-1:0] out_yaw_command,
  output logic signed [ANGLE_BITS-1:0] out_femur_command,
  output logic signed [ANGLE_BITS-1:0] out_tibia_command,
  output logic out_reachable,
  // configuration
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [lik_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lik_pkg::CFG_DATA_W-1:0] cfg_data
);
  localparam int CD = lik_pkg::COORD_W;
  localparam int WW = lik_pkg::WIDE_W;
  localparam int AW = lik_pkg::ANG_W;
  localparam int T2 = 2 * CD + 18 + 18 + 35 + 33 + 1;

  // clamp a coordinate to the signed 16 bit range
  function automatic logic signed [CD-1:0] sat_coord(input logic signed [COORD_BITS-1:0] v);
    logic signed [32:0] e;
    e = 33'(v);
    if (e > 33'sd32767) return 16'sh7fff;
    if (e < -33'sd32768) return 16'sh8000;
    return e[CD-1:0];
  endfunction

  // round to 1/16 degree, half up, and saturate
  function automatic logic signed [ANGLE_BITS-1:0] pack_angle(input logic signed [31:0] f);
    logic signed [31:0] v;
    v = (f + 32'sd2048) >>> lik_pkg::ROUND_SHIFT;
    if (v > 32'sd0 + ((32'sd1 <<< (ANGLE_BITS - 1)) - 32'sd1))
      v = (32'sd1 <<< (ANGLE_BITS - 1)) - 32'sd1;
    if (v < -(32'sd1 <<< (ANGLE_BITS - 1)))
      v = -(32'sd1 <<< (ANGLE_BITS - 1));
    return v[ANGLE_BITS-1:0];
  endfunction

  // configuration registers
  logic [13:0]        femur_offset_r, femur_length_r, tibia_length_r;
  logic signed [14:0] femur_height_r;
  logic               busy_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      femur_offset_r <= '0;
      femur_height_r <= '0;
      femur_length_r <= '0;
      tibia_length_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        lik_pkg::CFG_FEMUR_OFFSET: femur_offset_r <= cfg_data[13:0];
        lik_pkg::CFG_FEMUR_HEIGHT: femur_height_r <= $signed(cfg_data[14:0]);
        lik_pkg::CFG_FEMUR_LENGTH: femur_length_r <= cfg_data[13:0];
        lik_pkg::CFG_TIBIA_LENGTH: tibia_length_r <= cfg_data[13:0];
        default: ;
      endcase
    end
  end

  // busy only during and straight after reset
  always_ff @(posedge clk) begin
    if (!rst_n) busy_r <= 1'b1;
    else busy_r <= 1'b0;
  end
  assign busy = busy_r;

  // stage 0: capture and clamp the target
  logic s0_valid_r;
  logic signed [CD-1:0] s0_x_r, s0_y_r, s0_z_r;
  always_ff @(posedge clk) begin
    if (!rst_n) s0_valid_r <= 1'b0;
    else s0_valid_r <= start && !busy;
  end
  always_ff @(posedge clk) begin
    s0_x_r <= sat_coord(in_target_x);
    s0_y_r <= sat_coord(in_target_y);
    s0_z_r <= sat_coord(in_target_z);
  end

  // stage 1: squares of x and y
  logic s1_valid_r;
  logic [31:0] s1_xx_r, s1_yy_r;
  logic signed [CD-1:0] s1_x_r, s1_y_r, s1_z_r;
  always_ff @(posedge clk) begin
    if (!rst_n) s1_valid_r <= 1'b0;
    else s1_valid_r <= s0_valid_r;
  end
  always_ff @(posedge clk) begin
    s1_xx_r <= 32'(s0_x_r * s0_x_r);
    s1_yy_r <= 32'(s0_y_r * s0_y_r);
    s1_x_r  <= s0_x_r;
    s1_y_r  <= s0_y_r;
    s1_z_r  <= s0_z_r;
  end

  // stage 2: radial distance squared
  logic s2_valid_r;
  logic [31:0] s2_sum_r;
  logic [3*CD-1:0] s2_tag_r;
  always_ff @(posedge clk) begin
    if (!rst_n) s2_valid_r <= 1'b0;
    else s2_valid_r <= s1_valid_r;
  end
  always_ff @(posedge clk) begin
    s2_sum_r <= s1_xx_r + s1_yy_r;
    s2_tag_r <= {s1_x_r, s1_y_r, s1_z_r};
  end

  // rho
  logic            rho_valid;
  logic [15:0]     rho;
  logic [3*CD-1:0] rho_tag;
  lik_sqrt #(.W(32), .TW(3*CD)) u_rho_sqrt (
    .clk(clk), .rst_n(rst_n),
    .valid_i(s2_valid_r), .rad_i(s2_sum_r), .tag_i(s2_tag_r),
    .valid_o(rho_valid), .root_o(rho), .tag_o(rho_tag)
  );

  logic signed [CD-1:0] rho_x, rho_y, rho_z;
  assign rho_x = $signed(rho_tag[3*CD-1:2*CD]);
  assign rho_y = $signed(rho_tag[2*CD-1:CD]);
  assign rho_z = $signed(rho_tag[CD-1:0]);

  // stage A: foot in the leg plane
  logic sa_valid_r;
  logic signed [17:0] sa_x2_r, sa_y2_r;
  logic signed [CD-1:0] sa_x_r, sa_y_r;
  always_ff @(posedge clk) begin
    if (!rst_n) sa_valid_r <= 1'b0;
    else sa_valid_r <= rho_valid;
  end
  always_ff @(posedge clk) begin
    sa_x2_r <= $signed({2'b00, rho}) - $signed({4'b0000, femur_offset_r});
    sa_y2_r <= 18'(femur_height_r) - 18'(rho_z);
    sa_x_r  <= rho_x;
    sa_y_r  <= rho_y;
  end

  // stage B: squares
  logic sb_valid_r;
  logic [31:0] sb_x2sq_r, sb_y2sq_r;
  logic [27:0] sb_l1sq_r, sb_l2sq_r;
  logic signed [17:0] sb_x2_r, sb_y2_r;
  logic signed [CD-1:0] sb_x_r, sb_y_r;
  always_ff @(posedge clk) begin
    if (!rst_n) sb_valid_r <= 1'b0;
    else sb_valid_r <= sa_valid_r;
  end
  always_ff @(posedge clk) begin
    sb_x2sq_r <= 32'(sa_x2_r * sa_x2_r);
    sb_y2sq_r <= 32'(sa_y2_r * sa_y2_r);
    sb_l1sq_r <= 28'(femur_length_r * femur_length_r);
    sb_l2sq_r <= 28'(tibia_length_r * tibia_length_r);
    sb_x2_r   <= sa_x2_r;
    sb_y2_r   <= sa_y2_r;
    sb_x_r    <= sa_x_r;
    sb_y_r    <= sa_y_r;
  end

  // stage C: D and the length difference
  logic sc_valid_r;
  logic [32:0] sc_d2_r;
  logic signed [28:0] sc_lsd_r;
  logic [27:0] sc_l1sq_r;
  logic signed [17:0] sc_x2_r, sc_y2_r;
  logic signed [CD-1:0] sc_x_r, sc_y_r;
  always_ff @(posedge clk) begin
    if (!rst_n) sc_valid_r <= 1'b0;
    else sc_valid_r <= sb_valid_r;
  end
  always_ff @(posedge clk) begin
    sc_d2_r   <= 33'(sb_x2sq_r) + 33'(sb_y2sq_r);
    sc_lsd_r  <= $signed({1'b0, sb_l1sq_r}) - $signed({1'b0, sb_l2sq_r});
    sc_l1sq_r <= sb_l1sq_r;
    sc_x2_r   <= sb_x2_r;
    sc_y2_r   <= sb_y2_r;
    sc_x_r    <= sb_x_r;
    sc_y_r    <= sb_y_r;
  end

  // stage D: c
  logic sd_valid_r;
  logic signed [34:0] sd_c_r;
  logic [32:0] sd_d2_r;
  logic [27:0] sd_l1sq_r;
  logic signed [17:0] sd_x2_r, sd_y2_r;
  logic signed [CD-1:0] sd_x_r, sd_y_r;
  always_ff @(posedge clk) begin
    if (!rst_n) sd_valid_r <= 1'b0;
    else sd_valid_r <= sc_valid_r;
  end
  always_ff @(posedge clk) begin
    sd_c_r    <= $signed({2'b00, sc_d2_r}) + 35'(sc_lsd_r);
    sd_d2_r   <= sc_d2_r;
    sd_l1sq_r <= sc_l1sq_r;
    sd_x2_r   <= sc_x2_r;
    sd_y2_r   <= sc_y2_r;
    sd_x_r    <= sc_x_r;
    sd_y_r    <= sc_y_r;
  end

  // stage E: |c| and the 4*L1^2*D product
  logic [34:0] se_abs;
  assign se_abs = sd_c_r[34] ? 35'(-sd_c_r) : 35'(sd_c_r);

  logic se_valid_r, se_big_r;
  logic [31:0] se_ac_r;
  logic [63:0] se_q_r;
  logic signed [34:0] se_c_r;
  logic [32:0] se_d2_r;
  logic signed [17:0] se_x2_r, se_y2_r;
  logic signed [CD-1:0] se_x_r, se_y_r;
  always_ff @(posedge clk) begin
    if (!rst_n) se_valid_r <= 1'b0;
    else se_valid_r <= sd_valid_r;
  end
  always_ff @(posedge clk) begin
    se_ac_r  <= se_abs[31:0];
    se_big_r <= se_abs[34:32] != 3'b000;
    se_q_r   <= 64'(sd_l1sq_r * sd_d2_r) << 2;
    se_c_r   <= sd_c_r;
    se_d2_r  <= sd_d2_r;
    se_x2_r  <= sd_x2_r;
    se_y2_r  <= sd_y2_r;
    se_x_r   <= sd_x_r;
    se_y_r   <= sd_y_r;
  end

  // stage F: c squared
  logic sf_valid_r, sf_big_r;
  logic [63:0] sf_c2_r, sf_q_r;
  logic signed [34:0] sf_c_r;
  logic [32:0] sf_d2_r;
  logic signed [17:0] sf_x2_r, sf_y2_r;
  logic signed [CD-1:0] sf_x_r, sf_y_r;
  always_ff @(posedge clk) begin
    if (!rst_n) sf_valid_r <= 1'b0;
    else sf_valid_r <= se_valid_r;
  end
  always_ff @(posedge clk) begin
    sf_c2_r  <= se_ac_r * se_ac_r;
    sf_q_r   <= se_q_r;
    sf_big_r <= se_big_r;
    sf_c_r   <= se_c_r;
    sf_d2_r  <= se_d2_r;
    sf_x2_r  <= se_x2_r;
    sf_y2_r  <= se_y2_r;
    sf_x_r   <= se_x_r;
    sf_y_r   <= se_y_r;
  end

  // stage G: classify the discriminant
  logic sg_reach, sg_two;
  always_comb begin
    sg_reach = (sf_d2_r != '0) && !sf_big_r &&
               ({1'b0, sf_c2_r} < {1'b0, sf_q_r} + 65'(lik_pkg::EPS_UNITS + 1));
    sg_two   = ({1'b0, sf_c2_r} + 65'(lik_pkg::EPS_UNITS)) < {1'b0, sf_q_r};
  end

  logic sg_valid_r;
  logic [63:0] sg_disc_r;
  logic [T2-1:0] sg_tag_r;
  always_ff @(posedge clk) begin
    if (!rst_n) sg_valid_r <= 1'b0;
    else sg_valid_r <= sf_valid_r;
  end
  always_ff @(posedge clk) begin
    sg_disc_r <= sg_two ? sf_q_r - sf_c2_r : '0;
    sg_tag_r  <= {sf_x_r, sf_y_r, sf_x2_r, sf_y2_r, sf_c_r, sf_d2_r, sg_reach};
  end

  // S = rounded root of the negated discriminant
  logic          s_valid;
  logic [31:0]   s_root;
  logic [T2-1:0] s_tag;
  lik_sqrt #(.W(64), .TW(T2)) u_disc_sqrt (
    .clk(clk), .rst_n(rst_n),
    .valid_i(sg_valid_r), .rad_i(sg_disc_r), .tag_i(sg_tag_r),
    .valid_o(s_valid), .root_o(s_root), .tag_o(s_tag)
  );

  logic signed [CD-1:0] t_x, t_y;
  logic signed [17:0]   t_x2, t_y2;
  logic signed [34:0]   t_c;
  logic [32:0]          t_d2;
  logic                 t_reach;
  assign {t_x, t_y, t_x2, t_y2, t_c, t_d2, t_reach} = s_tag;

  // stage H: knee products
  logic sh_valid_r, sh_reach_r, sh_pos_r;
  logic signed [WW-1:0] sh_p1_r, sh_p2_r, sh_p3_r, sh_p4_r, sh_dx_r, sh_dy_r;
  logic signed [CD-1:0] sh_x_r, sh_y_r;
  always_ff @(posedge clk) begin
    if (!rst_n) sh_valid_r <= 1'b0;
    else sh_valid_r <= s_valid;
  end
  always_ff @(posedge clk) begin
    sh_p1_r    <= t_x2 * t_c;
    sh_p2_r    <= t_y2 * $signed({1'b0, s_root});
    sh_p3_r    <= t_y2 * t_c;
    sh_p4_r    <= t_x2 * $signed({1'b0, s_root});
    sh_dx_r    <= $signed({1'b0, t_d2}) * t_x2;
    sh_dy_r    <= $signed({1'b0, t_d2}) * t_y2;
    sh_pos_r   <= t_x2 > 18'sd0;
    sh_reach_r <= t_reach;
    sh_x_r     <= t_x;
    sh_y_r     <= t_y;
  end

  // stage I: knee point and knee-to-foot vector, both scaled by 2D
  logic signed [WW-1:0] si_kx, si_ky;
  always_comb begin
    si_kx = sh_pos_r ? sh_p1_r - sh_p2_r : sh_p1_r + sh_p2_r;
    si_ky = sh_pos_r ? sh_p3_r + sh_p4_r : sh_p3_r - sh_p4_r;
  end

  logic si_valid_r, si_reach_r;
  logic signed [WW-1:0] si_kx_r, si_ky_r, si_tx_r, si_ty_r, si_x_r, si_y_r;
  always_ff @(posedge clk) begin
    if (!rst_n) si_valid_r <= 1'b0;
    else si_valid_r <= sh_valid_r;
  end
  always_ff @(posedge clk) begin
    si_kx_r    <= si_kx;
    si_ky_r    <= si_ky;
    si_tx_r    <= (sh_dx_r <<< 1) - si_kx;
    si_ty_r    <= si_ky - (sh_dy_r <<< 1);
    si_x_r     <= WW'(sh_x_r);
    si_y_r     <= WW'(sh_y_r);
    si_reach_r <= sh_reach_r;
  end

  // three angle units in step
  logic yaw_valid, fem_valid, tib_valid, fem_reach;
  logic signed [AW-1:0] yaw_ang, fem_ang, tib_ang;

  lik_atan2 #(.TW(1)) u_yaw_atan (
    .clk(clk), .rst_n(rst_n), .valid_i(si_valid_r),
    .y_i(si_y_r), .x_i(si_x_r), .tag_i(1'b0),
    .valid_o(yaw_valid), .angle_o(yaw_ang), .tag_o()
  );
  lik_atan2 #(.TW(1)) u_femur_atan (
    .clk(clk), .rst_n(rst_n), .valid_i(si_valid_r),
    .y_i(si_ky_r), .x_i(si_kx_r), .tag_i(si_reach_r),
    .valid_o(fem_valid), .angle_o(fem_ang), .tag_o(fem_reach)
  );
  lik_atan2 #(.TW(1)) u_tibia_atan (
    .clk(clk), .rst_n(rst_n), .valid_i(si_valid_r),
    .y_i(si_ty_r), .x_i(si_tx_r), .tag_i(1'b0),
    .valid_o(tib_valid), .angle_o(tib_ang), .tag_o()
  );

  // output stage: offset, round, saturate, and zero femur and tibia when unreachable
  logic out_valid_r, out_reach_r;
  logic signed [ANGLE_BITS-1:0] out_yaw_r, out_femur_r, out_tibia_r;
  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else out_valid_r <= fem_valid;
  end
  always_ff @(posedge clk) begin
    out_yaw_r   <= pack_angle(32'(lik_pkg::RIGHT_ANGLE_FINE) + 32'(yaw_ang));
    out_femur_r <= fem_reach ? pack_angle(32'(lik_pkg::RIGHT_ANGLE_FINE) + 32'(fem_ang)) : '0;
    out_tibia_r <= fem_reach ? pack_angle(32'(fem_ang) + 32'(tib_ang)) : '0;
    out_reach_r <= fem_reach;
  end

  assign out_valid         = out_valid_r;
  assign out_yaw_command   = out_yaw_r;
  assign out_femur_command = out_femur_r;
  assign out_tibia_command = out_tibia_r;
  assign out_reachable     = out_reach_r;

  // checks
  `ASSERT_IMPLIES(a_units_aligned, clk, rst_n, fem_valid, yaw_valid && tib_valid)
  `ASSERT_NEXT(a_strobe_follows, clk, rst_n, fem_valid, out_valid)
  `ASSERT_IMPLIES(a_unreach_zero, clk, rst_n, out_valid && !out_reachable, out_femur_command == '0 && out_tibia_command == '0)
  `ASSERT_NEXT(a_busy_clears, clk, rst_n, 1'b1, !busy)
endmodule

// ----- verif/leg_ik_checker.sv -----
// Checker for the leg inverse kinematics block: watches the command, result and
// configuration channels, predicts each result and compares. Depends on lik_pkg.
`timescale 1ns / 1ps
module leg_ik_checker (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  input  logic busy,
  input  logic signed [15:0] in_target_x,
  input  logic signed [15:0] in_target_y,
  input  logic signed [15:0] in_target_z,
  input  logic out_valid,
  input  logic signed [13:0] out_yaw_command,
  input  logic signed [13:0] out_femur_command,
  input  logic signed [13:0] out_tibia_command,
  input  logic out_reachable,
  input  logic cfg_valid,
  input  logic cfg_ready,
  input  logic [lik_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [lik_pkg::CFG_DATA_W-1:0] cfg_data,
  output int mismatches,
  output int pending
);
  typedef struct {
    logic signed [13:0] yaw;
    logic signed [13:0] femur;
    logic signed [13:0] tibia;
    logic reach;
  } joint_cmd_t;

  // atan(2^-i) in 1/65536 degree
  localparam longint ATAN_STEP [16] = '{2949120, 1740967, 919879, 466945, 234379, 117304,
    58666, 29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115};
  localparam longint NEAR_EPS = 65;

  logic [13:0] leg_offset;
  logic signed [14:0] leg_height;
  logic [13:0] femur_len;
  logic [13:0] tibia_len;
  joint_cmd_t cmd_q[$];

  function automatic longint unsigned root_nearest(longint unsigned n);
    longint unsigned r, b, v;
    r = 0;
    b = 64'd1 << 62;
    v = n;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return (n - r * r > r) ? r + 1 : r;
  endfunction

  // vectoring CORDIC, result in 1/65536 degree within (-180, 180]
  function automatic longint heading_fine(longint yy, longint xx);
    longint base, acc, m, nx, ny, ax, ay;
    base = 0;
    acc = 0;
    if (xx == 0 && yy == 0) return 0;
    if (xx < 0) begin
      base = (yy >= 0) ? 180 * 65536 : -180 * 65536;
      xx = -xx;
      yy = -yy;
    end
    ax = xx < 0 ? -xx : xx;
    ay = yy < 0 ? -yy : yy;
    m = ax > ay ? ax : ay;
    while (m >= (64'sd1 <<< 30)) begin
      xx = xx >>> 1;
      yy = yy >>> 1;
      m = m >>> 1;
    end
    while (m < (64'sd1 <<< 29)) begin
      xx = xx * 2;
      yy = yy * 2;
      m = m * 2;
    end
    for (int i = 0; i < 16; i++) begin
      nx = xx;
      ny = yy;
      if (yy > 0) begin
        nx = xx + (yy >>> i);
        ny = yy - (xx >>> i);
        acc = acc + ATAN_STEP[i];
      end else if (yy < 0) begin
        nx = xx - (yy >>> i);
        ny = yy + (xx >>> i);
        acc = acc - ATAN_STEP[i];
      end
      xx = nx;
      yy = ny;
    end
    return base + acc;
  endfunction

  // round half up to 1/16 degree, saturate to the command width
  function automatic logic signed [13:0] to_command(longint fine);
    longint v;
    v = (fine + 2048) >>> 12;
    if (v > 8191) v = 8191;
    if (v < -8192) v = -8192;
    return v[13:0];
  endfunction

  function automatic joint_cmd_t solve_leg(longint x, longint y, longint z);
    joint_cmd_t r;
    longint rho, x2, y2, d2, l1, l2, c, s, kx, ky, af, at;
    longint unsigned ac, c2, q;
    r.yaw = to_command(90 * 65536 + heading_fine(y, x));
    r.femur = '0;
    r.tibia = '0;
    r.reach = 1'b0;
    rho = longint'(root_nearest(longint'(x * x + y * y)));
    x2 = rho - longint'(leg_offset);
    y2 = longint'(leg_height) - z;
    l1 = longint'(femur_len);
    l2 = longint'(tibia_len);
    d2 = x2 * x2 + y2 * y2;
    if (d2 != 0) begin
      c = d2 + l1 * l1 - l2 * l2;
      ac = c < 0 ? -c : c;
      if (ac < (64'd1 << 32)) begin
        c2 = ac * ac;
        q = 4 * longint'(l1 * l1) * d2;
        if (c2 < q + NEAR_EPS + 1) begin
          s = 0;
          if (c2 + NEAR_EPS < q) s = longint'(root_nearest(q - c2));
          if (x2 > 0) begin
            kx = x2 * c - y2 * s;
            ky = y2 * c + x2 * s;
          end else begin
            kx = x2 * c + y2 * s;
            ky = y2 * c - x2 * s;
          end
          af = heading_fine(ky, kx);
          at = heading_fine(ky - 2 * d2 * y2, 2 * d2 * x2 - kx);
          r.femur = to_command(90 * 65536 + af);
          r.tibia = to_command(af + at);
          r.reach = 1'b1;
        end
      end
    end
    return r;
  endfunction

  // track register writes, predict on each accepted target, compare each strobe
  always @(posedge clk) begin
    joint_cmd_t want;
    int errs;
    errs = 0;
    if (!rst_n) begin
      leg_offset <= '0;
      leg_height <= '0;
      femur_len <= '0;
      tibia_len <= '0;
      cmd_q.delete();
      mismatches <= 0;
      pending <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          lik_pkg::CFG_FEMUR_OFFSET: leg_offset <= cfg_data[13:0];
          lik_pkg::CFG_FEMUR_HEIGHT: leg_height <= cfg_data[14:0];
          lik_pkg::CFG_FEMUR_LENGTH: femur_len <= cfg_data[13:0];
          lik_pkg::CFG_TIBIA_LENGTH: tibia_len <= cfg_data[13:0];
          default: ;
        endcase
      end
      if (start && !busy)
        cmd_q.push_back(solve_leg(in_target_x, in_target_y, in_target_z));
      if (out_valid) begin
        if (cmd_q.size() == 0) begin
          $error("result with no transaction outstanding");
          errs = errs + 1;
        end else begin
          want = cmd_q.pop_front();
          if (out_yaw_command !== want.yaw) begin
            $error("yaw_command expected %0d actual %0d", want.yaw, out_yaw_command);
            errs = errs + 1;
          end
          if (out_femur_command !== want.femur) begin
            $error("femur_command expected %0d actual %0d", want.femur, out_femur_command);
            errs = errs + 1;
          end
          if (out_tibia_command !== want.tibia) begin
            $error("tibia_command expected %0d actual %0d", want.tibia, out_tibia_command);
            errs = errs + 1;
          end
          if (out_reachable !== want.reach) begin
            $error("reachable expected %0d actual %0d", want.reach, out_reachable);
            errs = errs + 1;
          end
        end
      end
      mismatches <= mismatches + errs;
      pending <= cmd_q.size();
    end
  end
endmodule

// ----- verif/leg_inverse_kinematics_tb.sv -----
// Testbench top for the leg inverse kinematics block: clock, reset, stimulus
// and verdict. Depends on lik_pkg, leg_ik_checker and the block itself.
`timescale 1ns / 1ps
module leg_inverse_kinematics_tb;
  localparam int IDLE_LIMIT = 5000;
  // an index that names no register
  localparam logic [lik_pkg::CFG_IDX_W-1:0] CFG_NO_REG = 8'd7;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  logic signed [15:0] in_target_x, in_target_y, in_target_z;
  logic out_valid;
  logic signed [13:0] out_yaw_command, out_femur_command, out_tibia_command;
  logic out_reachable;
  logic cfg_valid;
  logic cfg_ready;
  logic [lik_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [lik_pkg::CFG_DATA_W-1:0] cfg_data;
  int mismatches;
  int pending;
  int idle_cycles;
  int burst_mode;

  leg_inverse_kinematics uut (.*);

  leg_ik_checker chk (.*);

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // end the run when nothing has moved for too long
  always @(posedge clk) begin
    if ((start && !busy) || out_valid || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAIL leg_inverse_kinematics");
      $finish;
    end
  end

  // present one write and wait for its handshake; the caller drops valid
  task automatic write_reg(logic [lik_pkg::CFG_IDX_W-1:0] idx,
                           logic [lik_pkg::CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(negedge clk); while (!cfg_ready);
    @(posedge clk);
  endtask

  task automatic set_leg(int offs, int hgt, int fl, int tl);
    write_reg(lik_pkg::CFG_FEMUR_OFFSET, offs[15:0]);
    write_reg(lik_pkg::CFG_FEMUR_HEIGHT, hgt[15:0]);
    write_reg(lik_pkg::CFG_FEMUR_LENGTH, fl[15:0]);
    write_reg(lik_pkg::CFG_TIBIA_LENGTH, tl[15:0]);
    cfg_valid <= 1'b0;
  endtask

  // hold start low until every outstanding transaction has returned
  task automatic drain;
    start <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic send_target(int x, int y, int z);
    int r, gap;
    r = $urandom_range(0, 19);
    gap = 0;
    if (!burst_mode) begin
      if (r >= 17) gap = $urandom_range(10, 40);
      else if (r >= 11) gap = $urandom_range(1, 3);
    end
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_target_x <= x[15:0];
    in_target_y <= y[15:0];
    in_target_z <= z[15:0];
    do @(negedge clk); while (busy);
    @(posedge clk);
  endtask

  // mostly targets around the leg's working volume, some anywhere
  task automatic random_targets(int count, int span);
    for (int i = 0; i < count; i++) begin
      if (i % 60 == 0) burst_mode = ($urandom_range(0, 2) == 0);
      if ($urandom_range(0, 4) == 0)
        send_target($urandom_range(0, 65535) - 32768, $urandom_range(0, 65535) - 32768,
                    $urandom_range(0, 65535) - 32768);
      else
        send_target($urandom_range(0, 2 * span) - span, $urandom_range(0, 2 * span) - span,
                    $urandom_range(0, 2 * span) - span);
    end
  endtask

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_target_x = '0;
    in_target_y = '0;
    in_target_z = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    burst_mode = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: all lengths zero
    send_target(0, 0, 0);
    send_target(100, 50, -20);
    drain();

    // a typical leg, directed corners
    write_reg(CFG_NO_REG, 16'hFFFF);
    set_leg(480, 0, 960, 1280);
    send_target(0, 0, 5);
    send_target(-100, 0, 0);
    send_target(480, 0, 0);
    send_target(480 + 960 + 1280, 0, 0);
    send_target(1200, 600, -900);
    send_target(-1200, -600, 900);
    send_target(0, 1500, -1000);
    send_target(0, -1500, 1000);
    send_target(32767, 32767, 32767);
    send_target(-32768, -32768, -32768);
    send_target(32767, -32768, 0);
    send_target(-32768, 32767, 0);
    send_target(10000, 0, 0);
    send_target(100, 100, -2000);
    send_target(200, -1, 300);
    drain();
    random_targets(300, 3000);
    drain();

    // extremes of every register
    set_leg(16383, 16383, 16383, 16383);
    send_target(16383 + 32766, 0, 16383);
    random_targets(200, 32767);
    drain();
    set_leg(0, -16384, 16383, 0);
    random_targets(200, 32767);
    drain();
    set_leg(0, 0, 0, 16383);
    random_targets(150, 20000);
    drain();

    // equal segments, femur joint raised, then a leg with unequal segments
    set_leg(320, 800, 1600, 1600);
    send_target(320 + 3200, 0, 800);
    send_target(320, 0, 800);
    random_targets(250, 4000);
    drain();
    set_leg(100, -300, 700, 1500);
    random_targets(250, 2500);
    drain();

    repeat (120) @(posedge clk);
    if (mismatches == 0)
      $display("PASS leg_inverse_kinematics");
    else
      $display("FAIL leg_inverse_kinematics");
    $finish;
  end
endmodule

// ----- sim.f -----
+incdir+hw/rtl
hw/rtl/lik_pkg.sv
hw/rtl/lik_sqrt_cell.sv
hw/rtl/lik_sqrt.sv
hw/rtl/lik_cordic_cell.sv
hw/rtl/lik_atan2.sv
hw/rtl/leg_inverse_kinematics.sv
verif/leg_ik_checker.sv
verif/leg_inverse_kinematics_tb.sv
